// ----- rtl/tldc_pkg.sv -----
// Shared types and constants for the traffic light dimming controller.
// No dependencies; imported by tldc_dp, tldc_ctrl and the top level.
package tldc_pkg;

    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int BRIGHT_W    = 8;
    localparam int MAX_HEADS   = 4;
    localparam int LAMP_BITS   = 3;
    localparam int MASK_W      = MAX_HEADS * LAMP_BITS;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_W-1:0]    YELLOW_TIME_RST    = 16'd1500;
    localparam logic [CFG_W-1:0]    MAIN_TIME_RST      = 16'd8000;
    localparam logic [CFG_W-1:0]    BLINK_HALF_RST     = 16'd500;
    localparam logic [CFG_W-1:0]    PRESS_HOLDOFF_RST  = 16'd500;
    localparam logic [CFG_W-1:0]    SAMPLE_PERIOD_RST  = 16'd500;
    localparam logic [CFG_W-1:0]    PEAK_HOLD_RST      = 16'd60000;
    localparam logic [BRIGHT_W-1:0] MAX_BRIGHT_RST     = 8'd200;
    localparam logic [MAX_HEADS-1:0] START_PATTERN_RST = 4'd9;

    localparam int LAMP_RED    = 0;
    localparam int LAMP_YELLOW = 1;
    localparam int LAMP_GREEN  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_YELLOW_TIME   = 3'd0,
        REG_MAIN_TIME     = 3'd1,
        REG_BLINK_HALF    = 3'd2,
        REG_PRESS_HOLDOFF = 3'd3,
        REG_SAMPLE_PERIOD = 3'd4,
        REG_PEAK_HOLD     = 3'd5,
        REG_MAX_BRIGHT    = 3'd6,
        REG_START_PATTERN = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_RED    = 2'd0,
        PH_YELLOW = 2'd1,
        PH_GREEN  = 2'd2
    } phase_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_start;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/tldc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by tldc_dp.
module tldc_div #(
    parameter int DVD_W = 18,
    parameter int DVS_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dq_reg, dq_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign rem_shift = {rem_reg, dq_reg[DVD_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            dq_next  = {dq_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ----- rtl/tldc_dp.sv -----
// Datapath: configuration registers, timers, sensor peak tracking, lamp heads,
// brightness division and the output register. Depends on tldc_pkg, tldc_div.
module tldc_dp #(
    parameter int NUM_HEADS   = 4,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tldc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tldc_pkg::CFG_W-1:0]          cfg_data,
    input  logic [SAMPLE_BITS-1:0]              sensor_sample,
    input  logic                                button_level,
    input  tldc_pkg::dp_cmd_t                   cmd,
    output tldc_pkg::dp_status_t                status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [tldc_pkg::MASK_W-1:0]         lamp_mask,
    output logic [tldc_pkg::BRIGHT_W-1:0]       brightness,
    output logic                                flashing
);

    import tldc_pkg::*;

    localparam int  PROD_W     = BRIGHT_W + SAMPLE_BITS;
    localparam bit  HEADS_ODD  = (NUM_HEADS % 2) == 1;

    logic [CFG_W-1:0]    yellow_time_reg, yellow_time_next;
    logic [CFG_W-1:0]    main_time_reg, main_time_next;
    logic [CFG_W-1:0]    blink_half_reg, blink_half_next;
    logic [CFG_W-1:0]    press_holdoff_reg, press_holdoff_next;
    logic [CFG_W-1:0]    sample_period_reg, sample_period_next;
    logic [CFG_W-1:0]    peak_hold_reg, peak_hold_next;
    logic [BRIGHT_W-1:0] max_bright_reg, max_bright_next;

    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   sample_time_reg, sample_time_next;
    logic [TIME_W-1:0]   peak_time_reg, peak_time_next;
    logic [TIME_W-1:0]   press_time_reg, press_time_next;
    logic [TIME_W-1:0]   blink_time_reg, blink_time_next;
    logic                blink_on_reg, blink_on_next;
    logic                flash_mode_reg, flash_mode_next;
    logic [SAMPLE_BITS-1:0] held_reg, held_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    phase_t              phase_reg [NUM_HEADS];
    phase_t              phase_next [NUM_HEADS];
    logic                from_green_reg [NUM_HEADS];
    logic                from_green_next [NUM_HEADS];
    logic [TIME_W-1:0]   phase_start_reg [NUM_HEADS];
    logic [TIME_W-1:0]   phase_start_next [NUM_HEADS];

    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                in_button_reg;
    logic [MASK_W-1:0]   mask_reg, mask_next;

    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   lamp_mask_reg;
    logic [BRIGHT_W-1:0] brightness_reg;
    logic                flashing_reg;

    logic                sample_due, press_hit, blink_due, blink_half_zero;
    logic [TIME_W-1:0]   elapsed [NUM_HEADS];
    logic                seen_blink;
    logic                div_done;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-1:0]   quotient;
    logic [BRIGHT_W-1:0] bright_sat;

    assign sample_due      = (now_reg - sample_time_reg) > TIME_W'(sample_period_reg);
    assign press_hit       = in_button_reg &&
                             ((now_reg - press_time_reg) > TIME_W'(press_holdoff_reg));
    assign blink_due       = (now_reg - blink_time_reg) >= TIME_W'(blink_half_reg);
    assign blink_half_zero = blink_half_reg == '0;

    // config writes
    always_comb
    begin
        yellow_time_next   = yellow_time_reg;
        main_time_next     = main_time_reg;
        blink_half_next    = blink_half_reg;
        press_holdoff_next = press_holdoff_reg;
        sample_period_next = sample_period_reg;
        peak_hold_next     = peak_hold_reg;
        max_bright_next    = max_bright_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_YELLOW_TIME:   yellow_time_next   = cfg_data;
                REG_MAIN_TIME:     main_time_next     = cfg_data;
                REG_BLINK_HALF:    blink_half_next    = cfg_data;
                REG_PRESS_HOLDOFF: press_holdoff_next = cfg_data;
                REG_SAMPLE_PERIOD: sample_period_next = cfg_data;
                REG_PEAK_HOLD:     peak_hold_next     = cfg_data;
                REG_MAX_BRIGHT:    max_bright_next    = cfg_data[BRIGHT_W-1:0];
                REG_START_PATTERN: ;
            endcase
        end
    end

    // start pattern load and per-tick update
    always_comb
    begin
        now_next         = now_reg;
        sample_time_next = sample_time_reg;
        peak_time_next   = peak_time_reg;
        press_time_next  = press_time_reg;
        blink_time_next  = blink_time_reg;
        blink_on_next    = blink_on_reg;
        flash_mode_next  = flash_mode_reg;
        held_next        = held_reg;
        peak_next        = peak_reg;
        mask_next        = mask_reg;
        seen_blink       = 1'b0;
        for (int h = 0; h < NUM_HEADS; h++)
        begin
            elapsed[h]          = now_reg - phase_start_reg[h];
            phase_next[h]       = phase_reg[h];
            from_green_next[h]  = from_green_reg[h];
            phase_start_next[h] = phase_start_reg[h];
        end

        priority if (cfg_we && cfg_reg_t'(cfg_index) == REG_START_PATTERN)
        begin
            for (int h = 0; h < NUM_HEADS; h++)
                phase_next[h] = cfg_data[h] ? PH_GREEN : PH_RED;
        end
        else if (cmd.update)
        begin
            now_next = now_reg + TIME_W'(1);
            if (sample_due)
            begin
                held_next        = in_sample_reg;
                sample_time_next = now_reg;
                if (in_sample_reg > peak_reg ||
                    (now_reg - peak_time_reg) > TIME_W'(peak_hold_reg))
                begin
                    peak_next      = in_sample_reg;
                    peak_time_next = now_reg;
                end
            end
            if (press_hit)
            begin
                press_time_next = now_reg;
                flash_mode_next = !flash_mode_reg;
            end
            mask_next = '0;
            if (flash_mode_next)
            begin
                // zero half period: each head toggles again, so neighbors alternate
                if (blink_due)
                begin
                    blink_time_next = now_reg;
                    blink_on_next   = blink_on_reg ^ (!blink_half_zero || HEADS_ODD);
                end
                for (int h = 0; h < NUM_HEADS; h++)
                begin
                    seen_blink = blink_on_reg ^
                                 (blink_due && (!blink_half_zero || ((h & 1) == 0)));
                    mask_next[h*LAMP_BITS + LAMP_YELLOW] = seen_blink;
                end
            end
            else
            begin
                for (int h = 0; h < NUM_HEADS; h++)
                begin
                    if (phase_reg[h] == PH_YELLOW)
                    begin
                        if (elapsed[h] > TIME_W'(yellow_time_reg))
                            phase_next[h] = from_green_reg[h] ? PH_RED : PH_GREEN;
                    end
                    else if (elapsed[h] > TIME_W'(main_time_reg))
                    begin
                        from_green_next[h]  = phase_reg[h] == PH_GREEN;
                        phase_next[h]       = PH_YELLOW;
                        phase_start_next[h] = now_reg;
                    end
                    unique case (phase_next[h])
                        PH_YELLOW: mask_next[h*LAMP_BITS + LAMP_YELLOW] = 1'b1;
                        PH_GREEN:  mask_next[h*LAMP_BITS + LAMP_GREEN]  = 1'b1;
                        default:   mask_next[h*LAMP_BITS + LAMP_RED]    = 1'b1;
                    endcase
                end
            end
        end
        else
        begin
        end
    end

    assign product = PROD_W'(max_bright_reg) * PROD_W'(held_reg);

    tldc_div #(
        .DVD_W (PROD_W),
        .DVS_W (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign bright_sat = (peak_reg == '0) ? '0 :
                        (|quotient[PROD_W-1:BRIGHT_W]) ? '1 : quotient[BRIGHT_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yellow_time_reg   <= YELLOW_TIME_RST;
            main_time_reg     <= MAIN_TIME_RST;
            blink_half_reg    <= BLINK_HALF_RST;
            press_holdoff_reg <= PRESS_HOLDOFF_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            peak_hold_reg     <= PEAK_HOLD_RST;
            max_bright_reg    <= MAX_BRIGHT_RST;
            now_reg           <= '0;
            sample_time_reg   <= '0;
            peak_time_reg     <= '0;
            press_time_reg    <= '0;
            blink_time_reg    <= '0;
            blink_on_reg      <= 1'b0;
            flash_mode_reg    <= 1'b0;
            held_reg          <= '0;
            peak_reg          <= '0;
            out_valid_reg     <= 1'b0;
            for (int h = 0; h < NUM_HEADS; h++)
            begin
                phase_reg[h]       <= START_PATTERN_RST[h] ? PH_GREEN : PH_RED;
                from_green_reg[h]  <= 1'b0;
                phase_start_reg[h] <= '0;
            end
        end
        else
        begin
            yellow_time_reg   <= yellow_time_next;
            main_time_reg     <= main_time_next;
            blink_half_reg    <= blink_half_next;
            press_holdoff_reg <= press_holdoff_next;
            sample_period_reg <= sample_period_next;
            peak_hold_reg     <= peak_hold_next;
            max_bright_reg    <= max_bright_next;
            now_reg           <= now_next;
            sample_time_reg   <= sample_time_next;
            peak_time_reg     <= peak_time_next;
            press_time_reg    <= press_time_next;
            blink_time_reg    <= blink_time_next;
            blink_on_reg      <= blink_on_next;
            flash_mode_reg    <= flash_mode_next;
            held_reg          <= held_next;
            peak_reg          <= peak_next;
            out_valid_reg     <= out_valid_next;
            for (int h = 0; h < NUM_HEADS; h++)
            begin
                phase_reg[h]       <= phase_next[h];
                from_green_reg[h]  <= from_green_next[h];
                phase_start_reg[h] <= phase_start_next[h];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_sample_reg <= sensor_sample;
            in_button_reg <= button_level;
        end
        mask_reg <= mask_next;
        if (cmd.out_load)
        begin
            lamp_mask_reg  <= mask_reg;
            brightness_reg <= bright_sat;
            flashing_reg   <= flash_mode_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign lamp_mask  = lamp_mask_reg;
    assign brightness = brightness_reg;
    assign flashing   = flashing_reg;

endmodule

// ----- rtl/tldc_ctrl.sv -----
// Sequencer for one tick: capture, state update, brightness divide, output load.
// Depends on tldc_pkg.
module tldc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tldc_pkg::dp_status_t status,
    output tldc_pkg::dp_cmd_t    cmd
);

    import tldc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV_START,
        S_DIV_WAIT,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_UPDATE;
            S_UPDATE:    state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:  if (status.div_done) state_next = S_LOAD;
            S_LOAD:      if (status.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready      = state_reg == S_IDLE;
    assign cmd.capture   = in_valid && (state_reg == S_IDLE);
    assign cmd.update    = state_reg == S_UPDATE;
    assign cmd.div_start = state_reg == S_DIV_START;
    assign cmd.out_load  = (state_reg == S_LOAD) && status.out_free;

endmodule

// ----- rtl/traffic_light_dimming_controller.sv -----
// Top level of the traffic light dimming controller.
// Depends on tldc_pkg, tldc_ctrl, tldc_dp (which holds tldc_div).
//
// Each input transfer is one 1 ms tick carrying a light sample and the button
// level; each tick yields exactly one output transfer with the lamp mask, the
// lamp brightness and the flashing flag.
// Channels: in_valid/in_ready and out_valid/out_ready; configuration through
// cfg_we/cfg_index/cfg_data; it is the user's duty that these are written only
// while no tick is in flight; the block itself does not enforce it.
// The brightness divider is bit-serial. A tick is taken only while idle, and
// in_ready returns in the cycle after the result is loaded, so a new tick is
// not taken before the previous result has been loaded.
// The result sits in an output register; a finished result waiting there
// does not block the next tick's update and divide, only its final load.
// If the receiver stalls, the block holds the finished result and stops
// before loading the next one.
// Reset: configuration returns to its defaults, timers and peak clear, heads
// start green or red per the default start pattern, no output is valid.
module traffic_light_dimming_controller #(
    parameter int NUM_HEADS   = 4,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tldc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tldc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SAMPLE_BITS-1:0]              sensor_sample,
    input  logic                                button_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tldc_pkg::MASK_W-1:0]         lamp_mask,
    output logic [tldc_pkg::BRIGHT_W-1:0]       brightness,
    output logic                                flashing
);

    import tldc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tldc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tldc_dp #(
        .NUM_HEADS   (NUM_HEADS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sensor_sample (sensor_sample),
        .button_level  (button_level),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .lamp_mask     (lamp_mask),
        .brightness    (brightness),
        .flashing      (flashing)
    );

endmodule

// ----- dv/tb_traffic_light_dimming_controller.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for traffic_light_dimming_controller: a directed tick table,
// then randomized register settings and ticks with random input/output pacing.
// Depends on tldc_pkg and the traffic_light_dimming_controller RTL.
module tb_traffic_light_dimming_controller;
    import tldc_pkg::*;

    localparam int HEADS          = MAX_HEADS;
    localparam int SAMPLE_W       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 30;
    localparam int LONG_HOLD      = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_TICKS    = 127;
    localparam int PRESSURE_PHASE = 4;
    localparam int DIR_ROWS       = 24;

    typedef struct packed {
        logic [MASK_W-1:0]   mask;
        logic [BRIGHT_W-1:0] bright;
        logic                flash;
    } tick_result_t;

    typedef struct packed {
        bit                  reprogram;
        logic [SAMPLE_W-1:0] sample;
        logic                button;
        bit                  typed;
        tick_result_t        want;
    } stim_row_t;

    // heads 0 and 3 green, heads 1 and 2 red, nothing latched yet
    localparam logic [MASK_W-1:0] RESET_MASK = 12'h84C;
    localparam tick_result_t RESET_TICK = '{RESET_MASK, 8'd0, 1'b0};
    localparam tick_result_t NO_TICK    = '0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [SAMPLE_W-1:0] sensor_sample;
    logic button_level;
    logic out_valid;
    logic out_ready;
    logic [MASK_W-1:0] lamp_mask;
    logic [BRIGHT_W-1:0] brightness;
    logic flashing;

    traffic_light_dimming_controller #(
        .NUM_HEADS   (HEADS),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sensor_sample (sensor_sample),
        .button_level  (button_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lamp_mask     (lamp_mask),
        .brightness    (brightness),
        .flashing      (flashing)
    );

    // predictor state and register copies
    logic [TIME_W-1:0] now_ms, latch_ms, peak_ms, press_ms, blink_ms;
    logic blink_lit, flash_on;
    logic [SAMPLE_W-1:0] held_level, peak_level;
    phase_t head_ph [HEADS];
    logic from_green [HEADS];
    logic [TIME_W-1:0] yellow_entry_ms [HEADS];
    logic [CFG_W-1:0] yellow_len, main_len, blink_len, holdoff_len, latch_len, peak_hold_len;
    logic [BRIGHT_W-1:0] bright_max;
    logic [MAX_HEADS-1:0] start_heads;

    tick_result_t expected_ticks [$];
    logic [CFG_W-1:0] reg_plan [8];
    int errors = 0;
    int burst_left = 0;
    logic long_hold_req = 1'b0;
    logic row_typed;
    tick_result_t row_want;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{1'b0, 10'd0,    1'b0, 1'b1, RESET_TICK},
        '{1'b0, 10'd1023, 1'b0, 1'b1, RESET_TICK},
        '{1'b0, 10'd0,    1'b1, 1'b1, RESET_TICK},
        '{1'b0, 10'd1023, 1'b1, 1'b1, RESET_TICK},
        '{1'b0, 10'd512,  1'b0, 1'b1, RESET_TICK},
        '{1'b0, 10'd1,    1'b1, 1'b1, RESET_TICK},
        '{1'b0, 10'd1022, 1'b0, 1'b1, RESET_TICK},
        '{1'b0, 10'd341,  1'b1, 1'b1, RESET_TICK},
        // short timers, zero blink period, new start pattern
        '{1'b1, 10'd0,    1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd0,    1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd700,  1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd1023, 1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd350,  1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd1,    1'b1, 1'b0, NO_TICK},
        '{1'b0, 10'd1023, 1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd512,  1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd0,    1'b1, 1'b0, NO_TICK},
        '{1'b0, 10'd100,  1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd200,  1'b1, 1'b0, NO_TICK},
        '{1'b0, 10'd300,  1'b1, 1'b0, NO_TICK},
        '{1'b0, 10'd400,  1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd1023, 1'b1, 1'b0, NO_TICK},
        '{1'b0, 10'd0,    1'b0, 1'b0, NO_TICK},
        '{1'b0, 10'd0,    1'b0, 1'b0, NO_TICK}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void load_heads();
        for (int h = 0; h < HEADS; h++)
        begin
            head_ph[h] = start_heads[h] ? PH_GREEN : PH_RED;
        end
    endfunction

    function automatic tick_result_t predict_tick(logic [SAMPLE_W-1:0] sample, logic button);
        tick_result_t res;
        logic [TIME_W-1:0] now;
        int unsigned quotient;
        now = now_ms;
        res = '0;
        if (now - latch_ms > latch_len)
        begin
            held_level = sample;
            latch_ms = now;
            if (sample > peak_level || now - peak_ms > peak_hold_len)
            begin
                peak_level = sample;
                peak_ms = now;
            end
        end
        if (button && now - press_ms > holdoff_len)
        begin
            press_ms = now;
            flash_on = !flash_on;
        end
        if (peak_level != 0)
        begin
            quotient = (32'(bright_max) * 32'(held_level)) / 32'(peak_level);
            res.bright = (quotient > 255) ? 8'd255 : quotient[BRIGHT_W-1:0];
        end
        for (int h = 0; h < HEADS; h++)
        begin
            if (flash_on)
            begin
                // shared blink timer is retested per head
                if (now - blink_ms >= blink_len)
                begin
                    blink_lit = !blink_lit;
                    blink_ms = now;
                end
                if (blink_lit)
                    res.mask[LAMP_BITS*h + LAMP_YELLOW] = 1'b1;
            end
            else
            begin
                if (head_ph[h] == PH_YELLOW)
                begin
                    if (now - yellow_entry_ms[h] > yellow_len)
                        head_ph[h] = from_green[h] ? PH_RED : PH_GREEN;
                end
                else if (now - yellow_entry_ms[h] > main_len)
                begin
                    from_green[h] = (head_ph[h] == PH_GREEN);
                    head_ph[h] = PH_YELLOW;
                    yellow_entry_ms[h] = now;
                end
                case (head_ph[h])
                    PH_YELLOW: res.mask[LAMP_BITS*h + LAMP_YELLOW] = 1'b1;
                    PH_GREEN:  res.mask[LAMP_BITS*h + LAMP_GREEN] = 1'b1;
                    default:   res.mask[LAMP_BITS*h + LAMP_RED] = 1'b1;
                endcase
            end
        end
        now_ms = now + TIME_W'(1);
        res.flash = flash_on;
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return CFG_W'($urandom_range(13, 300));
            default: return CFG_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic program_regs();
        cfg_reg_t r;
        r = r.first();
        repeat (r.num())
        begin
            cfg_we <= 1'b1;
            cfg_index <= r;
            cfg_data <= reg_plan[r];
            @(posedge clk);
            case (r)
                REG_YELLOW_TIME:   yellow_len = reg_plan[r];
                REG_MAIN_TIME:     main_len = reg_plan[r];
                REG_BLINK_HALF:    blink_len = reg_plan[r];
                REG_PRESS_HOLDOFF: holdoff_len = reg_plan[r];
                REG_SAMPLE_PERIOD: latch_len = reg_plan[r];
                REG_PEAK_HOLD:     peak_hold_len = reg_plan[r];
                REG_MAX_BRIGHT:    bright_max = reg_plan[r][BRIGHT_W-1:0];
                REG_START_PATTERN:
                begin
                    start_heads = reg_plan[r][MAX_HEADS-1:0];
                    load_heads();
                end
                default: ;
            endcase
            r = r.next();
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input logic [SAMPLE_W-1:0] sample, input logic button,
                             input bit typed, input tick_result_t want);
        in_valid <= 1'b1;
        sensor_sample <= sample;
        button_level <= button;
        row_typed <= typed;
        row_want <= want;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_quiet();
        @(posedge clk);
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : tick_capture
        tick_result_t predicted;
        if (rst_n && in_valid && in_ready)
        begin
            predicted = predict_tick(sensor_sample, button_level);
            expected_ticks.push_back(row_typed ? row_want : predicted);
        end
    end

    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_ticks.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected transfer: mask %03h bright %0d flash %0b",
                             lamp_mask, brightness, flashing);
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (lamp_mask !== want.mask || brightness !== want.bright
                    || flashing !== want.flash)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: mask %03h/%03h bright %0d/%0d flash %0b/%0b (exp/got)",
                                 want.mask, lamp_mask, want.bright, brightness,
                                 want.flash, flashing);
                end
            end
        end
    end

    initial
    begin : rx_pacing
        int unsigned mode, window, count;
        mode = 0;
        window = 0;
        count = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (window == 0)
                begin
                    mode = $urandom_range(0, 3);
                    window = $urandom_range(50, 400);
                end
                window--;
                count++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 5) == 0);
                    default: out_ready <= ((count % 8) < 5);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("traffic_light_dimming_controller verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] sample;
        logic button;
        bit dark;
        int unsigned press_odds;

        cfg_we <= 1'b0;
        cfg_index <= REG_YELLOW_TIME;
        cfg_data <= '0;
        in_valid <= 1'b0;
        sensor_sample <= '0;
        button_level <= 1'b0;
        row_typed <= 1'b0;
        row_want <= NO_TICK;
        rst_n <= 1'b0;

        yellow_len = YELLOW_TIME_RST;
        main_len = MAIN_TIME_RST;
        blink_len = BLINK_HALF_RST;
        holdoff_len = PRESS_HOLDOFF_RST;
        latch_len = SAMPLE_PERIOD_RST;
        peak_hold_len = PEAK_HOLD_RST;
        bright_max = MAX_BRIGHT_RST;
        start_heads = START_PATTERN_RST;
        now_ms = '0;
        latch_ms = '0;
        peak_ms = '0;
        press_ms = '0;
        blink_ms = '0;
        blink_lit = 1'b0;
        flash_on = 1'b0;
        held_level = '0;
        peak_level = '0;
        for (int h = 0; h < HEADS; h++)
        begin
            from_green[h] = 1'b0;
            yellow_entry_ms[h] = '0;
        end
        load_heads();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (directed_rows[i].reprogram)
            begin
                in_valid <= 1'b0;
                wait_quiet();
                // yellow, main, blink, holdoff, period, peak hold, max, start pattern
                reg_plan = '{16'd2, 16'd3, 16'd0, 16'd0, 16'd0, 16'd2, 16'd255, 16'd6};
                program_regs();
            end
            send_tick(directed_rows[i].sample, directed_rows[i].button,
                      directed_rows[i].typed, directed_rows[i].want);
        end
        in_valid <= 1'b0;
        wait_quiet();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            for (int i = REG_YELLOW_TIME; i <= REG_PEAK_HOLD; i++)
            begin
                if (p == 0)
                    reg_plan[i] = '1;
                else if (p == 1)
                    reg_plan[i] = '0;
                else
                    reg_plan[i] = pick_span();
            end
            if (p == 0)
                reg_plan[REG_MAX_BRIGHT] = 16'd255;
            else if (p == 1)
                reg_plan[REG_MAX_BRIGHT] = '0;
            else
                reg_plan[REG_MAX_BRIGHT] = CFG_W'($urandom);
            reg_plan[REG_START_PATTERN] = CFG_W'($urandom_range(0, 15));
            program_regs();

            dark = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       press_odds = 1;
                1:       press_odds = 3;
                default: press_odds = 30;
            endcase

            for (int k = 0; k < PHASE_TICKS; k++)
            begin
                case ($urandom_range(0, 15))
                    0, 1:    sample = '0;
                    2:       sample = '1;
                    default: sample = dark ? SAMPLE_W'($urandom_range(0, 3))
                                           : SAMPLE_W'($urandom);
                endcase
                button = ($urandom_range(0, press_odds) == 0);
                if (p == PRESSURE_PHASE && k == 10)
                    long_hold_req = 1'b1;
                send_tick(sample, button, 1'b0, NO_TICK);
            end
            in_valid <= 1'b0;
            wait_quiet();
        end

        if (errors == 0)
            $display("traffic_light_dimming_controller verification clean");
        else
            $display("traffic_light_dimming_controller verification failed");
        $finish;
    end

endmodule
